/* rtl/core/udg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the unit direction generator.
// No dependencies.
package udg_pkg;

    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int COMP_W    = 16;
    localparam int QF        = 60;
    localparam int OCT_STEPS = 3;
    localparam int TERMS     = 12;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd16;
    localparam logic [QF-1:0]      PI4_Q60     = 60'hC90FDAA22168C23;
    localparam logic [QF:0]        ONE_Q       = 61'd1 << QF;

    typedef struct packed {
        logic       valid;
        logic       err;
        logic [2:0] oct;
    } udg_ctl_t;

    // hh * 2^60 + (hl + lh) * 2^30 + ll
    function automatic logic [121:0] pp_sum(input logic [60:0] hh, input logic [60:0] hl,
                                            input logic [60:0] lh, input logic [60:0] ll);
        logic [121:0] acc;
        acc = {1'b0, hh, 60'd0} + {31'd0, hl, 30'd0} + {31'd0, lh, 30'd0} + {61'd0, ll};
        return acc;
    endfunction

endpackage

/* rtl/core/unit_direction_generator.sv */
`timescale 1ns / 1ps
// Unit direction generator: takes an index per cycle unless stalled; returns
// (cos, sin) of 2*pi*k/N. Uses udg_pkg, udg_div_cell and udg_taylor_cell.
//
// Accepts one index every cycle while s_tready is high. Each index passes
// through the cell chains in order: three division steps fold the index into
// an octant, sixty one-bit division steps form the Q60 octant angle, and
// twelve five-stage Taylor cells evaluate sine and cosine together. N must
// be written through the cfg port only while the block is idle; the block
// does not enforce this. N is clamped to MAX_DIRS; an index of N or more
// returns zero components with the error flag in m_tuser. The axis directions
// are exact and opposite directions are exact negatives.
module unit_direction_generator import udg_pkg::*; #(
    parameter int MAX_DIRS  = 4096,
    parameter int FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data,   // direction_count
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,    // [11:0] dir_index
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,    // [15:0] cos_val, [31:16] sin_val
    output logic                m_tuser     // index_error
);

    localparam logic [16:0]  MAX_W = 17'(MAX_DIRS);
    localparam int           SH    = QF - FRAC_BITS;
    localparam logic [61:0]  HALF  = 62'd1 << (SH - 1);

    typedef enum logic [1:0] {
        QD_EAST,
        QD_NORTH,
        QD_WEST,
        QD_SOUTH
    } quad_t;

    logic en;

    // configuration
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // entry stage
    logic [COUNT_W-1:0] n_next;
    udg_ctl_t           ctl_a_next, ctl_a_reg;
    logic [COUNT_W-1:0] n_a_reg;
    logic [INDEX_W-1:0] k_a_reg;

    always_comb begin
        n_next           = ({4'd0, count_reg} > MAX_W) ? MAX_W[COUNT_W-1:0] : count_reg;
        ctl_a_next.valid = s_tvalid;
        ctl_a_next.err   = ({1'b0, s_tdata[INDEX_W-1:0]} >= n_next);
        ctl_a_next.oct   = 3'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= ctl_a_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_a_reg <= n_next;
            k_a_reg <= s_tdata[INDEX_W-1:0];
        end
    end

    // octant: 8k / n
    udg_ctl_t           oc_ctl  [0:OCT_STEPS];
    logic [COUNT_W-1:0] oc_n    [0:OCT_STEPS];
    logic [COUNT_W-1:0] oc_rem  [0:OCT_STEPS];
    logic [2:0]         oc_word [0:OCT_STEPS];

    assign oc_ctl[0]  = ctl_a_reg;
    assign oc_n[0]    = n_a_reg;
    assign oc_rem[0]  = {1'b0, k_a_reg};
    assign oc_word[0] = 3'd0;

    for (genvar g = 0; g < OCT_STEPS; g++) begin : g_oct
        udg_div_cell #(.WORD_W(3)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctl_in   (oc_ctl[g]),
            .n_in     (oc_n[g]),
            .rem_in   (oc_rem[g]),
            .word_in  (oc_word[g]),
            .ctl_out  (oc_ctl[g+1]),
            .n_out    (oc_n[g+1]),
            .rem_out  (oc_rem[g+1]),
            .word_out (oc_word[g+1])
        );
    end

    // fold into the octant
    udg_ctl_t           ctl_b_next, ctl_b_reg;
    logic [COUNT_W-1:0] n_b_reg, t_b_reg;

    always_comb begin
        ctl_b_next     = oc_ctl[OCT_STEPS];
        ctl_b_next.oct = oc_word[OCT_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_b_reg <= '0;
        end else if (en) begin
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_b_reg <= oc_n[OCT_STEPS];
            t_b_reg <= oc_word[OCT_STEPS][0] ? (oc_n[OCT_STEPS] - oc_rem[OCT_STEPS])
                                             : oc_rem[OCT_STEPS];
        end
    end

    // numerator (pi/4) * t in Q60
    udg_ctl_t           ctl_c_reg, ctl_d_reg;
    logic [COUNT_W-1:0] n_c_reg, n_d_reg;
    logic [44:0]        lo_c_reg;
    logic [40:0]        hi_c_reg;
    logic [72:0]        num_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end else if (en) begin
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_c_reg   <= n_b_reg;
            lo_c_reg  <= {13'd0, PI4_Q60[31:0]} * {32'd0, t_b_reg};
            hi_c_reg  <= {13'd0, PI4_Q60[59:32]} * {28'd0, t_b_reg};
            n_d_reg   <= n_c_reg;
            num_d_reg <= {hi_c_reg, 32'd0} + {28'd0, lo_c_reg};
        end
    end

    // octant angle: numerator / n, one quotient bit per cell
    udg_ctl_t           an_ctl  [0:QF];
    logic [COUNT_W-1:0] an_n    [0:QF];
    logic [COUNT_W-1:0] an_rem  [0:QF];
    logic [QF-1:0]      an_word [0:QF];

    assign an_ctl[0]  = ctl_d_reg;
    assign an_n[0]    = n_d_reg;
    assign an_rem[0]  = num_d_reg[72:60];
    assign an_word[0] = num_d_reg[59:0];

    for (genvar g = 0; g < QF; g++) begin : g_ang
        udg_div_cell #(.WORD_W(QF)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctl_in   (an_ctl[g]),
            .n_in     (an_n[g]),
            .rem_in   (an_rem[g]),
            .word_in  (an_word[g]),
            .ctl_out  (an_ctl[g+1]),
            .n_out    (an_n[g+1]),
            .rem_out  (an_rem[g+1]),
            .word_out (an_word[g+1])
        );
    end

    // x^2
    udg_ctl_t      ctl_e_reg, ctl_f_reg;
    logic [QF-1:0] x_e_reg, x_f_reg, x2_f_reg;
    logic [60:0]   e_hh_reg, e_hl_reg, e_lh_reg, e_ll_reg;
    logic [121:0]  x2_sum;

    assign x2_sum = pp_sum(e_hh_reg, e_hl_reg, e_lh_reg, e_ll_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_e_reg <= '0;
            ctl_f_reg <= '0;
        end else if (en) begin
            ctl_e_reg <= an_ctl[QF];
            ctl_f_reg <= ctl_e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_e_reg  <= an_word[QF];
            e_hh_reg <= {31'd0, an_word[QF][59:30]} * {31'd0, an_word[QF][59:30]};
            e_hl_reg <= {31'd0, an_word[QF][59:30]} * {31'd0, an_word[QF][29:0]};
            e_lh_reg <= {31'd0, an_word[QF][29:0]} * {31'd0, an_word[QF][59:30]};
            e_ll_reg <= {31'd0, an_word[QF][29:0]} * {31'd0, an_word[QF][29:0]};
            x_f_reg  <= x_e_reg;
            x2_f_reg <= x2_sum[119:60];
        end
    end

    // Taylor chain
    udg_ctl_t      ty_ctl    [0:TERMS];
    logic [QF-1:0] ty_x2     [0:TERMS];
    logic [QF:0]   ty_term_s [0:TERMS];
    logic [QF:0]   ty_term_c [0:TERMS];
    logic [QF:0]   ty_acc_s  [0:TERMS];
    logic [QF:0]   ty_acc_c  [0:TERMS];

    assign ty_ctl[0]    = ctl_f_reg;
    assign ty_x2[0]     = x2_f_reg;
    assign ty_term_s[0] = {1'b0, x_f_reg};
    assign ty_term_c[0] = ONE_Q;
    assign ty_acc_s[0]  = {1'b0, x_f_reg};
    assign ty_acc_c[0]  = ONE_Q;

    for (genvar g = 0; g < TERMS; g++) begin : g_ty
        udg_taylor_cell #(.IDX(g + 1)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .ctl_in     (ty_ctl[g]),
            .x2_in      (ty_x2[g]),
            .term_s_in  (ty_term_s[g]),
            .term_c_in  (ty_term_c[g]),
            .acc_s_in   (ty_acc_s[g]),
            .acc_c_in   (ty_acc_c[g]),
            .ctl_out    (ty_ctl[g+1]),
            .x2_out     (ty_x2[g+1]),
            .term_s_out (ty_term_s[g+1]),
            .term_c_out (ty_term_c[g+1]),
            .acc_s_out  (ty_acc_s[g+1]),
            .acc_c_out  (ty_acc_c[g+1])
        );
    end

    // rotate back and round
    udg_ctl_t          ctl_z;
    logic [3:0]        oct_inc;
    quad_t             quad;
    logic              sneg, xn, yn;
    logic [QF:0]       mag_x, mag_y;
    logic [61:0]       rnd_x, rnd_y;
    logic [COMP_W-1:0] vx, vy, cos_next, sin_next;

    always_comb begin
        ctl_z   = ty_ctl[TERMS];
        sneg    = ctl_z.oct[0];
        oct_inc = {1'b0, ctl_z.oct} + 4'd1;
        quad    = quad_t'(oct_inc[2:1]);
        case (quad)
            QD_NORTH: begin
                mag_x = ty_acc_s[TERMS]; xn = !sneg;
                mag_y = ty_acc_c[TERMS]; yn = 1'b0;
            end
            QD_WEST: begin
                mag_x = ty_acc_c[TERMS]; xn = 1'b1;
                mag_y = ty_acc_s[TERMS]; yn = !sneg;
            end
            QD_SOUTH: begin
                mag_x = ty_acc_s[TERMS]; xn = sneg;
                mag_y = ty_acc_c[TERMS]; yn = 1'b1;
            end
            default: begin
                mag_x = ty_acc_c[TERMS]; xn = 1'b0;
                mag_y = ty_acc_s[TERMS]; yn = sneg;
            end
        endcase
        rnd_x = ({1'b0, mag_x} + HALF) >> SH;
        rnd_y = ({1'b0, mag_y} + HALF) >> SH;
        vx    = rnd_x[COMP_W-1:0];
        vy    = rnd_y[COMP_W-1:0];
        if (ctl_z.err) begin
            cos_next = '0;
            sin_next = '0;
        end else begin
            cos_next = xn ? (16'd0 - vx) : vx;
            sin_next = yn ? (16'd0 - vy) : vy;
        end
    end

    // output register with skid word
    logic              out_valid_reg, skid_valid_reg;
    logic [COMP_W-1:0] out_cos_reg, out_sin_reg, skid_cos_reg, skid_sin_reg;
    logic              out_err_reg, skid_err_reg;
    logic              out_take, new_word;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign out_take = out_valid_reg && m_tready;
    assign new_word = en && ctl_z.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_take) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (new_word) begin
                if (!out_valid_reg || out_take) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_cos_reg <= skid_cos_reg;
                out_sin_reg <= skid_sin_reg;
                out_err_reg <= skid_err_reg;
            end
        end else if (new_word) begin
            if (!out_valid_reg || out_take) begin
                out_cos_reg <= cos_next;
                out_sin_reg <= sin_next;
                out_err_reg <= ctl_z.err;
            end else begin
                skid_cos_reg <= cos_next;
                skid_sin_reg <= sin_next;
                skid_err_reg <= ctl_z.err;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sin_reg, out_cos_reg};
    assign m_tuser  = out_err_reg;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid word filled without an output stall");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
        else $error("index error word with non-zero components");
`endif

endmodule

/* rtl/core/udg_div_cell.sv */
`timescale 1ns / 1ps
// One restoring division step: shifts a dividend bit into the remainder,
// shifts the quotient bit into the word. Depends on udg_pkg.
module udg_div_cell import udg_pkg::*; #(
    parameter int WORD_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  udg_ctl_t            ctl_in,
    input  logic [COUNT_W-1:0]  n_in,
    input  logic [COUNT_W-1:0]  rem_in,
    input  logic [WORD_W-1:0]   word_in,
    output udg_ctl_t            ctl_out,
    output logic [COUNT_W-1:0]  n_out,
    output logic [COUNT_W-1:0]  rem_out,
    output logic [WORD_W-1:0]   word_out
);

    logic [COUNT_W:0]   shifted;
    logic [COUNT_W:0]   diff;
    logic               ge;
    logic [COUNT_W-1:0] rem_next;
    logic [WORD_W-1:0]  word_next;

    udg_ctl_t           ctl_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [WORD_W-1:0]  word_reg;

    always_comb begin
        shifted   = {rem_in, word_in[WORD_W-1]};
        diff      = shifted - {1'b0, n_in};
        ge        = (shifted >= {1'b0, n_in});
        rem_next  = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
        word_next = {word_in[WORD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_in;
            rem_reg  <= rem_next;
            word_reg <= word_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign n_out    = n_reg;
    assign rem_out  = rem_reg;
    assign word_out = word_reg;

endmodule

/* rtl/core/udg_taylor_cell.sv */
`timescale 1ns / 1ps
// One Taylor term for sine and cosine: Q60 multiply by x^2, exact floored
// divide by the factorial step, alternating accumulate. Depends on udg_pkg.
module udg_taylor_cell import udg_pkg::*; #(
    parameter int IDX = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  udg_ctl_t      ctl_in,
    input  logic [QF-1:0] x2_in,
    input  logic [QF:0]   term_s_in,
    input  logic [QF:0]   term_c_in,
    input  logic [QF:0]   acc_s_in,
    input  logic [QF:0]   acc_c_in,
    output udg_ctl_t      ctl_out,
    output logic [QF-1:0] x2_out,
    output logic [QF:0]   term_s_out,
    output logic [QF:0]   term_c_out,
    output logic [QF:0]   acc_s_out,
    output logic [QF:0]   acc_c_out
);

    localparam int unsigned DS = (2 * IDX) * (2 * IDX + 1);
    localparam int unsigned DC = (2 * IDX - 1) * (2 * IDX);
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    localparam logic [71:0] RECIP_S_FULL = ((72'd1 << (QF + LS)) + 72'(DS) - 72'd1) / DS;
    localparam logic [71:0] RECIP_C_FULL = ((72'd1 << (QF + LC)) + 72'(DC) - 72'd1) / DC;
    localparam logic [QF:0] RECIP_S = RECIP_S_FULL[QF:0];
    localparam logic [QF:0] RECIP_C = RECIP_C_FULL[QF:0];
    localparam logic SUB = ((IDX % 2) == 1);

    // stage 1: partial products of term * x^2
    udg_ctl_t      ctl_1_reg;
    logic [QF-1:0] x2_1_reg;
    logic [QF:0]   acc_s_1_reg, acc_c_1_reg;
    logic [60:0]   s_hh_1_reg, s_hl_1_reg, s_lh_1_reg, s_ll_1_reg;
    logic [60:0]   c_hh_1_reg, c_hl_1_reg, c_lh_1_reg, c_ll_1_reg;
    // stage 2: truncated Q60 product
    udg_ctl_t      ctl_2_reg;
    logic [QF-1:0] x2_2_reg;
    logic [QF:0]   acc_s_2_reg, acc_c_2_reg;
    logic [QF-1:0] p_s_2_reg, p_c_2_reg;
    logic [121:0]  sum_s_1, sum_c_1;
    // stage 3: partial products of product * reciprocal
    udg_ctl_t      ctl_3_reg;
    logic [QF-1:0] x2_3_reg;
    logic [QF:0]   acc_s_3_reg, acc_c_3_reg;
    logic [60:0]   s_hh_3_reg, s_hl_3_reg, s_lh_3_reg, s_ll_3_reg;
    logic [60:0]   c_hh_3_reg, c_hl_3_reg, c_lh_3_reg, c_ll_3_reg;
    // stage 4: quotient
    udg_ctl_t      ctl_4_reg;
    logic [QF-1:0] x2_4_reg;
    logic [QF:0]   acc_s_4_reg, acc_c_4_reg;
    logic [QF-1:0] q_s_4_reg, q_c_4_reg;
    logic [121:0]  sum_s_3, sum_c_3, shr_s_3, shr_c_3;
    // stage 5: accumulate
    udg_ctl_t      ctl_5_reg;
    logic [QF-1:0] x2_5_reg;
    logic [QF:0]   term_s_5_reg, term_c_5_reg, acc_s_5_reg, acc_c_5_reg;

    always_comb begin
        sum_s_1 = pp_sum(s_hh_1_reg, s_hl_1_reg, s_lh_1_reg, s_ll_1_reg);
        sum_c_1 = pp_sum(c_hh_1_reg, c_hl_1_reg, c_lh_1_reg, c_ll_1_reg);
        sum_s_3 = pp_sum(s_hh_3_reg, s_hl_3_reg, s_lh_3_reg, s_ll_3_reg);
        sum_c_3 = pp_sum(c_hh_3_reg, c_hl_3_reg, c_lh_3_reg, c_ll_3_reg);
        shr_s_3 = sum_s_3 >> (QF + LS);
        shr_c_3 = sum_c_3 >> (QF + LC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_1_reg <= '0;
            ctl_2_reg <= '0;
            ctl_3_reg <= '0;
            ctl_4_reg <= '0;
            ctl_5_reg <= '0;
        end else if (en) begin
            ctl_1_reg <= ctl_in;
            ctl_2_reg <= ctl_1_reg;
            ctl_3_reg <= ctl_2_reg;
            ctl_4_reg <= ctl_3_reg;
            ctl_5_reg <= ctl_4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_1_reg    <= x2_in;
            acc_s_1_reg <= acc_s_in;
            acc_c_1_reg <= acc_c_in;
            s_hh_1_reg  <= {30'd0, term_s_in[60:30]} * {31'd0, x2_in[59:30]};
            s_hl_1_reg  <= {30'd0, term_s_in[60:30]} * {31'd0, x2_in[29:0]};
            s_lh_1_reg  <= {31'd0, term_s_in[29:0]} * {31'd0, x2_in[59:30]};
            s_ll_1_reg  <= {31'd0, term_s_in[29:0]} * {31'd0, x2_in[29:0]};
            c_hh_1_reg  <= {30'd0, term_c_in[60:30]} * {31'd0, x2_in[59:30]};
            c_hl_1_reg  <= {30'd0, term_c_in[60:30]} * {31'd0, x2_in[29:0]};
            c_lh_1_reg  <= {31'd0, term_c_in[29:0]} * {31'd0, x2_in[59:30]};
            c_ll_1_reg  <= {31'd0, term_c_in[29:0]} * {31'd0, x2_in[29:0]};

            x2_2_reg    <= x2_1_reg;
            acc_s_2_reg <= acc_s_1_reg;
            acc_c_2_reg <= acc_c_1_reg;
            p_s_2_reg   <= sum_s_1[119:60];
            p_c_2_reg   <= sum_c_1[119:60];

            x2_3_reg    <= x2_2_reg;
            acc_s_3_reg <= acc_s_2_reg;
            acc_c_3_reg <= acc_c_2_reg;
            s_hh_3_reg  <= {31'd0, p_s_2_reg[59:30]} * {30'd0, RECIP_S[60:30]};
            s_hl_3_reg  <= {31'd0, p_s_2_reg[59:30]} * {31'd0, RECIP_S[29:0]};
            s_lh_3_reg  <= {31'd0, p_s_2_reg[29:0]} * {30'd0, RECIP_S[60:30]};
            s_ll_3_reg  <= {31'd0, p_s_2_reg[29:0]} * {31'd0, RECIP_S[29:0]};
            c_hh_3_reg  <= {31'd0, p_c_2_reg[59:30]} * {30'd0, RECIP_C[60:30]};
            c_hl_3_reg  <= {31'd0, p_c_2_reg[59:30]} * {31'd0, RECIP_C[29:0]};
            c_lh_3_reg  <= {31'd0, p_c_2_reg[29:0]} * {30'd0, RECIP_C[60:30]};
            c_ll_3_reg  <= {31'd0, p_c_2_reg[29:0]} * {31'd0, RECIP_C[29:0]};

            x2_4_reg    <= x2_3_reg;
            acc_s_4_reg <= acc_s_3_reg;
            acc_c_4_reg <= acc_c_3_reg;
            q_s_4_reg   <= shr_s_3[QF-1:0];
            q_c_4_reg   <= shr_c_3[QF-1:0];

            x2_5_reg     <= x2_4_reg;
            term_s_5_reg <= {1'b0, q_s_4_reg};
            term_c_5_reg <= {1'b0, q_c_4_reg};
            acc_s_5_reg  <= SUB ? (acc_s_4_reg - {1'b0, q_s_4_reg})
                                : (acc_s_4_reg + {1'b0, q_s_4_reg});
            acc_c_5_reg  <= SUB ? (acc_c_4_reg - {1'b0, q_c_4_reg})
                                : (acc_c_4_reg + {1'b0, q_c_4_reg});
        end
    end

    assign ctl_out    = ctl_5_reg;
    assign x2_out     = x2_5_reg;
    assign term_s_out = term_s_5_reg;
    assign term_c_out = term_c_5_reg;
    assign acc_s_out  = acc_s_5_reg;
    assign acc_c_out  = acc_c_5_reg;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for unit_direction_generator: streams direction indices, predicts each
// (cos, sin, error) word in 64-bit fixed point and checks every result in order.
// Depends on udg_pkg and the unit_direction_generator RTL.
module tb_top;
    import udg_pkg::*;

    localparam int MAX_DIRS    = 4096;
    localparam int FRAC_BITS   = 14;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 160;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 55;
    localparam int REPORT_CAP  = 200;

    localparam logic [1:0] QUAD_EAST  = 2'd0;
    localparam logic [1:0] QUAD_NORTH = 2'd1;
    localparam logic [1:0] QUAD_WEST  = 2'd2;
    localparam logic [1:0] QUAD_SOUTH = 2'd3;

    typedef logic [63:0] u64_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] cos_val;
        logic signed [COMP_W-1:0] sin_val;
        logic                     index_error;
    } direction_word_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;   // [11:0] dir_index
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;          // [15:0] cos_val, [31:16] sin_val
    logic                m_tuser;          // index_error

    direction_word_t     pending_dirs[$];
    logic [COUNT_W-1:0]  count_reg = COUNT_RESET;
    int                  fail_count = 0;
    int                  cycle_count = 0;
    int                  sink_wait = 0;
    bit                  src_fast = 1'b0;
    bit                  sink_fast = 1'b0;

    unit_direction_generator #(
        .MAX_DIRS  (MAX_DIRS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic u64_t q60_mul(input u64_t a, input u64_t b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor((pi/4) * t / n) in Q60, split in two halves to stay within 64 bits
    function automatic u64_t octant_angle_q60(input u64_t t, input u64_t n);
        u64_t pi_hi, pi_lo, prod, quo, rem, frac;
        pi_hi = {36'd0, PI4_Q60[59:32]};
        pi_lo = {32'd0, PI4_Q60[31:0]};
        prod  = pi_hi * t;
        quo   = prod / n;
        rem   = prod % n;
        frac  = ((rem << 32) + pi_lo * t) / n;
        return (quo << 32) + frac;
    endfunction

    function automatic logic [COMP_W-1:0] round_q14(input u64_t mag, input bit neg);
        u64_t v;
        v = (mag + (64'd1 << (QF - FRAC_BITS - 1))) >> (QF - FRAC_BITS);
        if (neg)
            v = 64'd0 - v;
        return v[COMP_W-1:0];
    endfunction

    function automatic direction_word_t predict_direction(input logic [INDEX_W-1:0] k,
                                                         input logic [COUNT_W-1:0] count);
        direction_word_t w;
        u64_t n, m, oct, r, t, x, x2, s, c, term, xv, yv;
        bit xn, yn, sneg;
        logic [1:0] quad;
        n = {51'd0, count};
        if (n > u64_t'(MAX_DIRS))
            n = u64_t'(MAX_DIRS);
        w = '0;
        if ({52'd0, k} >= n) begin
            w.index_error = 1'b1;
            return w;
        end
        m   = 64'd8 * {52'd0, k};
        oct = m / n;
        r   = m % n;
        t   = oct[0] ? n - r : r;
        x   = octant_angle_q60(t, n);
        x2  = q60_mul(x, x);
        s = x;
        term = x;
        for (int i = 1; i <= TERMS; i++) begin
            term = q60_mul(term, x2) / u64_t'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) s = s - term;
            else s = s + term;
        end
        c = 64'd1 << QF;
        term = 64'd1 << QF;
        for (int i = 1; i <= TERMS; i++) begin
            term = q60_mul(term, x2) / u64_t'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) c = c - term;
            else c = c + term;
        end
        // odd octants mirror the sine before the quadrant rotation
        sneg = oct[0];
        quad = oct[2:1] + {1'b0, oct[0]};
        case (quad)
            QUAD_NORTH: begin xv = s; xn = !sneg; yv = c; yn = 1'b0;  end
            QUAD_WEST:  begin xv = c; xn = 1'b1;  yv = s; yn = !sneg; end
            QUAD_SOUTH: begin xv = s; xn = sneg;  yv = c; yn = 1'b1;  end
            default:    begin xv = c; xn = 1'b0;  yv = s; yn = sneg;  end
        endcase
        w.cos_val = round_q14(xv, xn);
        w.sin_val = round_q14(yv, yn);
        return w;
    endfunction

    // ---------------------------------------------------------------- result side

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            if (pending_dirs.size() == 0) begin
                fail_count++;
                $error("result word with nothing expected: tdata %h tuser %b",
                       m_tdata, m_tuser);
            end else begin
                direction_word_t want;
                want = pending_dirs.pop_front();
                if (m_tdata[15:0] !== want.cos_val) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $error("cos_val: expected %0d, got %0d",
                               want.cos_val, $signed(m_tdata[15:0]));
                end
                if (m_tdata[31:16] !== want.sin_val) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $error("sin_val: expected %0d, got %0d",
                               want.sin_val, $signed(m_tdata[31:16]));
                end
                if (m_tuser !== want.index_error) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $error("index_error: expected %0d, got %0d",
                               want.index_error, m_tuser);
                end
            end
            if (!sink_fast) begin
                int w;
                w = $urandom_range(0, 16);
                if (w > 0) begin
                    m_tready  <= 1'b0;
                    sink_wait <= w - 1;
                end
            end
        end else if (!m_tready) begin
            if (sink_wait == 0) m_tready <= 1'b1;
            else sink_wait <= sink_wait - 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_index(input logic [INDEX_W-1:0] k);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'd0, k};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_dirs.push_back(predict_direction(k, count_reg));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dirs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] n);
        wait_drained();
        cfg_data  <= n;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        count_reg = n;
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return COUNT_W'(4 * $urandom_range(1, 1024));
            1:       return COUNT_W'($urandom_range(1, 16));
            2:       return COUNT_W'($urandom_range(MAX_DIRS + 1, 8191));
            3:       return COUNT_W'(4 * $urandom_range(1, 64));
            default: return COUNT_W'($urandom_range(1, MAX_DIRS));
        endcase
    endfunction

    // default count of sixteen: axes, one diagonal, indices 1, 3 and 15, first bad index, top index
    task automatic test_reset_count();
        logic [INDEX_W-1:0] picks[10];
        picks = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd8, 12'd12, 12'd15, 12'd16, 12'd4095};
        foreach (picks[i]) send_index(picks[i]);
    endtask

    // count of one, zero, the maximum, saturation above it, and one not divisible by four
    task automatic test_count_extremes();
        write_count(COUNT_W'(1));
        send_index(12'd0);
        send_index(12'd1);
        send_index(12'd4095);
        write_count(COUNT_W'(0));
        send_index(12'd0);
        send_index(12'd4095);
        write_count(COUNT_W'(8191));
        send_index(12'd4095);
        send_index(12'd0);
        send_index(12'd1024);
        send_index(12'd2048);
        send_index(12'd3072);
        send_index(12'd2047);
        write_count(COUNT_W'(MAX_DIRS));
        send_index(12'd4095);
        write_count(COUNT_W'(3));
        for (int k = 0; k < 4; k++) send_index(INDEX_W'(k));
    endtask

    task automatic test_random_indices();
        int lim;
        for (int p = 0; p < PHASES; p++) begin
            write_count(pick_count());
            src_fast  = ($urandom_range(0, 3) == 0);
            sink_fast = ($urandom_range(0, 3) == 0);
            lim = (int'(count_reg) > MAX_DIRS) ? MAX_DIRS : int'(count_reg);
            for (int j = 0; j < PHASE_WORDS; j++) begin
                if (p == PHASES / 2 && j == PHASE_WORDS / 2)
                    wait_drained();
                if (lim > 0 && $urandom_range(0, 9) < 8)
                    send_index(INDEX_W'($urandom_range(0, lim - 1)));
                else
                    send_index(INDEX_W'($urandom_range(0, 4095)));
            end
        end
        src_fast  = 1'b0;
        sink_fast = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_count();
        test_count_extremes();
        test_random_indices();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (pending_dirs.size() != 0) begin
            fail_count++;
            $error("%0d result words never arrived", pending_dirs.size());
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
